// File: rtl/gifs_pkg.sv
// Shared types, constants and helpers for the GIF neuron step block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package gifs_pkg;

    // Depth of the after-spike kernel and of the future current chain.
    localparam int KERNEL_TAPS = 64;

    localparam int DATA_W    = 32;
    localparam int TAP_IDX_W = 6;
    localparam int NOISE_W   = 20;
    localparam int CFG_IDX_W = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration channel.
    localparam cfg_idx_t REG_REST   = 4'd0;
    localparam cfg_idx_t REG_THRESH = 4'd1;
    localparam cfg_idx_t REG_RPOT   = 4'd2;
    localparam cfg_idx_t REG_NGAIN  = 4'd3;
    localparam cfg_idx_t REG_DECAY  = 4'd4;
    localparam cfg_idx_t REG_CGAIN  = 4'd5;
    localparam cfg_idx_t REG_SUBS   = 4'd6;
    localparam cfg_idx_t REG_FRAC   = 4'd7;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_FRAC,
        ST_GAIN
    } gifs_state_t;

    typedef struct packed {
        logic [31:0] rest;
        logic [31:0] thr;
        logic [31:0] rpot;
        logic [30:0] ngain;
        logic [16:0] d1;
        logic [16:0] d2;
        logic [4:0]  subs;
        logic [16:0] frac;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rest:  32'd0,
        thr:   32'd65536,
        rpot:  32'd0,
        ngain: 31'd0,
        d1:    17'd65536,
        d2:    17'd65536,
        subs:  5'd1,
        frac:  17'd65536
    };

    typedef struct packed {
        logic step;
        logic spike;
        logic we;
    } cell_ctl_t;

    typedef struct packed {
        logic                 step;
        logic                 spike;
        logic                 we;
        logic [TAP_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    value;
    } chain_ctl_t;

    typedef struct packed {
        logic start;
        logic drive_en;
        logic frac_en;
        logic gain_en;
    } arith_ctl_t;

    // Saturate a sign-extended value to 32-bit signed.
    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [32:0] hi;
        hi = x[63:31];
        if (hi == '0 || hi == '1)
        begin
            return x[31:0];
        end
        else if (x[63])
        begin
            return 32'h8000_0000;
        end
        else
        begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/gifs_if.sv
// Handshake channels of the GIF neuron step block: requests, results, config.
// Depends on gifs_pkg for field widths.
`default_nettype none

interface gifs_item_if;
    import gifs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [TAP_IDX_W-1:0] tap_index;
    logic [DATA_W-1:0]    tap_value;
    logic [DATA_W-1:0]    drive_current;
    logic [NOISE_W-1:0]   noise_sample;

    modport source (output valid, op, tap_index, tap_value, drive_current, noise_sample,
                    input ready);
    modport sink   (input valid, op, tap_index, tap_value, drive_current, noise_sample,
                    output ready);
endinterface

interface gifs_result_if;
    import gifs_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] voltage;
    logic              spike;
    logic [DATA_W-1:0] history_current;

    modport source (output valid, voltage, spike, history_current, input ready);
    modport sink   (input valid, voltage, spike, history_current, output ready);
endinterface

interface gifs_cfg_if;
    import gifs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/gifs_cell.sv
// One cell of the future-current chain: holds one pending current and one kernel tap.
// Depends on gifs_pkg (cell_ctl_t, sat32).
`default_nettype none

module gifs_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gifs_pkg::cell_ctl_t       ctl,
    input  logic [gifs_pkg::DATA_W-1:0] wdata,
    input  logic [gifs_pkg::DATA_W-1:0] sum_in,
    output logic [gifs_pkg::DATA_W-1:0] sum_out
);
    import gifs_pkg::*;

    logic [DATA_W-1:0] fut_reg, fut_next;
    logic [DATA_W-1:0] tap_reg, tap_next;
    logic signed [DATA_W:0] add_w;

    // On a spiking step the tap lands on this entry before it moves one place down.
    assign add_w   = (DATA_W+1)'($signed(fut_reg)) + (DATA_W+1)'($signed(tap_reg));
    assign sum_out = ctl.spike ? sat32(64'(add_w)) : fut_reg;

    always_comb
    begin
        fut_next = ctl.step ? sum_in : fut_reg;
        tap_next = ctl.we ? wdata : tap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fut_reg <= '0;
            tap_reg <= '0;
        end
        else
        begin
            fut_reg <= fut_next;
            tap_reg <= tap_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gifs_chain.sv
// Row of KERNEL_TAPS chain cells; cell 0 is the entry consumed by the current step.
// Depends on gifs_pkg and gifs_cell.
`default_nettype none

module gifs_chain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gifs_pkg::chain_ctl_t        ctl,
    output logic [gifs_pkg::DATA_W-1:0] head
);
    import gifs_pkg::*;

    logic [DATA_W-1:0] sum_w [KERNEL_TAPS];
    logic [DATA_W-1:0] in_w  [KERNEL_TAPS];

    assign head = sum_w[0];

    for (genvar j = 0; j < KERNEL_TAPS; j++)
    begin : g_cell
        cell_ctl_t cctl;

        assign cctl = '{
            step:  ctl.step,
            spike: ctl.spike,
            we:    ctl.we && (32'(ctl.idx) == 32'(j))
        };

        // The far end refills with an empty entry.
        if (j == KERNEL_TAPS - 1)
        begin : g_tail
            assign in_w[j] = '0;
        end
        else
        begin : g_link
            assign in_w[j] = sum_w[j+1];
        end

        gifs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cctl),
            .wdata   (ctl.value),
            .sum_in  (in_w[j]),
            .sum_out (sum_w[j])
        );
    end

endmodule

`default_nettype wire

// File: rtl/gifs_arith.sv
// Fixed-point datapath of one neuron step: drive interpolation, current gain, voltage.
// Holds voltage, previous drive and substep count. Depends on gifs_pkg.
`default_nettype none

module gifs_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gifs_pkg::cfg_t               cfg,
    input  gifs_pkg::arith_ctl_t         ctl,
    input  logic [gifs_pkg::DATA_W-1:0]  drive,
    input  logic [gifs_pkg::NOISE_W-1:0] noise,
    input  logic [gifs_pkg::DATA_W-1:0]  head,
    output logic                         spiking,
    output logic [gifs_pkg::DATA_W-1:0]  voltage,
    output logic                         spike,
    output logic [gifs_pkg::DATA_W-1:0]  hist
);
    import gifs_pkg::*;

    localparam int DIFF_W = 33;
    localparam int FC_W   = 22;
    localparam int PD_W   = 56;
    localparam int DI_W   = 40;
    localparam int PA_W   = 51;
    localparam int PB_W   = 50;
    localparam int PN_W   = 52;
    localparam int Q_W    = 58;
    localparam int TOT_W  = 42;
    localparam int BN_W   = 38;
    localparam int C_W    = 60;
    localparam int SUM_W  = 46;

    // Architectural state
    logic [31:0] volt_reg, volt_next;
    logic [31:0] prev_reg, prev_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        first_reg, first_next;

    // Stage registers
    logic                     spike_reg;
    logic signed [DIFF_W-1:0] diff_reg, opa_reg;
    logic [FC_W-1:0]          fc_reg;
    logic [NOISE_W-1:0]       noise_reg;
    logic [31:0]              drive_reg, hist_reg;
    logic signed [DI_W-1:0]   di_reg;
    logic signed [PA_W-1:0]   ma_reg;
    logic signed [PB_W-1:0]   mb_reg;
    logic signed [PN_W-1:0]   mn_reg;
    logic signed [TOT_W-1:0]  tot_reg;
    logic signed [BN_W-1:0]   bn_reg;

    logic signed [31:0]     rest_s, vprev_s;
    logic                   spike_w;
    logic signed [PD_W-1:0] p_di;
    logic signed [DI_W-1:0] di_w;
    logic signed [17:0]     kd_w;
    logic signed [PA_W-1:0] ma_w;
    logic signed [PB_W-1:0] mb_w;
    logic signed [PN_W-1:0] mn_w;
    logic signed [Q_W-1:0]  q_w;
    logic signed [TOT_W-1:0] tot_w;
    logic signed [BN_W-1:0] bn_w;
    logic signed [C_W-1:0]  c_w;
    logic signed [SUM_W-1:0] vsum_w;
    logic [31:0]            vnew_w;
    logic                   wrap_w;

    assign rest_s = $signed(cfg.rest);

    // Accept: previous voltage, spike decision, drive difference, interpolation weight.
    assign vprev_s = first_reg ? (cfg.rest[31] ? rest_s : 32'sd0) : $signed(volt_reg);
    assign spike_w = vprev_s > $signed(cfg.thr);

    // Drive stage: (drive - prev) * f * (c+1), plus the voltage-base and noise products.
    assign p_di = PD_W'(diff_reg) * PD_W'($signed({1'b0, fc_reg}));
    assign di_w = DI_W'($signed(prev_reg)) + $signed(p_di[PD_W-1:16]);
    assign kd_w = 18'sd65536 - $signed({1'b0, cfg.d1});
    assign ma_w = PA_W'(opa_reg) * PA_W'($signed({1'b0, cfg.d1}));
    assign mb_w = PB_W'(rest_s) * PB_W'(kd_w);
    assign mn_w = PN_W'($signed(noise_reg)) * PN_W'($signed({1'b0, cfg.ngain}));

    // Fraction stage: history + fl(di * f); base + noise term.
    assign q_w   = Q_W'(di_reg) * Q_W'($signed({1'b0, cfg.frac}));
    assign tot_w = TOT_W'($signed(hist_reg)) + $signed(q_w[Q_W-1:16]);
    assign bn_w  = BN_W'($signed(ma_reg[PA_W-1:16]))
                 + (spike_reg ? BN_W'($signed(mb_reg[PB_W-1:16])) : BN_W'(rest_s))
                 + BN_W'($signed(mn_reg[PN_W-1:16]));

    // Gain stage: fl(total * d2) and the saturated new voltage.
    assign c_w    = C_W'(tot_reg) * C_W'($signed({1'b0, cfg.d2}));
    assign vsum_w = SUM_W'($signed(c_w[C_W-1:16])) + SUM_W'(bn_reg);
    assign vnew_w = sat32(64'(vsum_w));

    assign wrap_w = (({1'b0, cnt_reg} + 5'd1) >= cfg.subs) || (cnt_reg == 4'd15);

    assign spiking = spike_reg;
    assign voltage = vnew_w;
    assign spike   = $signed(vnew_w) > $signed(cfg.thr);
    assign hist    = hist_reg;

    always_comb
    begin
        volt_next  = volt_reg;
        prev_next  = prev_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        if (ctl.start)
        begin
            first_next = 1'b0;
        end
        if (ctl.gain_en)
        begin
            volt_next = vnew_w;
            if (wrap_w)
            begin
                cnt_next  = '0;
                prev_next = drive_reg;
            end
            else
            begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg  <= '0;
            prev_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
            spike_reg <= 1'b0;
        end
        else
        begin
            volt_reg  <= volt_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            if (ctl.start)
            begin
                spike_reg <= spike_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            diff_reg  <= DIFF_W'($signed(drive)) - DIFF_W'($signed(prev_reg));
            fc_reg    <= FC_W'(cfg.frac) * FC_W'({1'b0, cnt_reg} + 5'd1);
            opa_reg   <= spike_w ? DIFF_W'($signed(cfg.rpot))
                                 : DIFF_W'(vprev_s) - DIFF_W'(rest_s);
            noise_reg <= noise;
            drive_reg <= drive;
        end
        if (ctl.drive_en)
        begin
            di_reg   <= di_w;
            ma_reg   <= ma_w;
            mb_reg   <= mb_w;
            mn_reg   <= mn_w;
            hist_reg <= head;
        end
        if (ctl.frac_en)
        begin
            tot_reg <= tot_w;
            bn_reg  <= bn_w;
        end
    end

endmodule

`default_nettype wire

// File: rtl/spiking_neuron_gif_step.sv
// Top level of the generalized integrate-and-fire neuron step block.
// Depends on gifs_pkg, gifs_if (channels), gifs_chain, gifs_cell, gifs_arith.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------------------
//   item     | in  | valid/ready   | op, tap_index, tap_value, drive_current,
//            |     |               | noise_sample
//   result   | out | valid/ready   | voltage, spike, history_current
//   cfg      | in  | valid/ready   | index (register 0..7), data
//
// A step request passes through accept, then the drive, fraction and gain stages,
// set by the chain of three dependent multiplies through the voltage update.
// A kernel load request writes its tap when accepted and yields no result.
// The result sits in an output register, so the next request is accepted while it
// waits; a step whose result finds that register still full holds in its gain stage.
// Reset loads register defaults and clears the future chain and all kernel taps
// directly (all flip-flops, no clearing pass). cfg is always ready.
`default_nettype none

module spiking_neuron_gif_step (
    input  logic          clk,
    input  logic          rst_n,
    gifs_item_if.sink     item,
    gifs_result_if.source result,
    gifs_cfg_if.sink      cfg
);
    import gifs_pkg::*;

    gifs_state_t state_reg, state_next;
    cfg_t        cfg_reg, cfg_next;

    // Output register
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] res_volt_reg;
    logic              res_spike_reg;
    logic [DATA_W-1:0] res_hist_reg;

    arith_ctl_t        actl;
    chain_ctl_t        cctl;
    logic              load_w;
    logic              out_free_w;
    logic              spiking_w;
    logic [DATA_W-1:0] head_w;
    logic [DATA_W-1:0] volt_w;
    logic              spike_w;
    logic [DATA_W-1:0] hist_w;

    // Output register may take a new result when empty or being drained.
    assign out_free_w = !res_valid_reg || result.ready;

    // -------------------------------------------------------------------------
    // Sequencer
    // -------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && item.op == OP_STEP)
                begin
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: state_next = ST_FRAC;
            ST_FRAC:  state_next = ST_GAIN;
            ST_GAIN:
            begin
                if (out_free_w)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready    = 1'b0;
        load_w        = 1'b0;
        actl.start    = 1'b0;
        actl.drive_en = 1'b0;
        actl.frac_en  = 1'b0;
        actl.gain_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                load_w     = item.valid && item.op == OP_LOAD;
                actl.start = item.valid && item.op == OP_STEP;
            end
            ST_DRIVE: actl.drive_en = 1'b1;
            ST_FRAC:  actl.frac_en  = 1'b1;
            ST_GAIN:  actl.gain_en  = out_free_w;
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // -------------------------------------------------------------------------
    // Configuration registers; out-of-range indexes are dropped.
    // -------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_REST:   cfg_next.rest  = cfg.data;
                REG_THRESH: cfg_next.thr   = cfg.data;
                REG_RPOT:   cfg_next.rpot  = cfg.data;
                REG_NGAIN:  cfg_next.ngain = cfg.data[30:0];
                REG_DECAY:  cfg_next.d1    = cfg.data[16:0];
                REG_CGAIN:  cfg_next.d2    = cfg.data[16:0];
                REG_SUBS:   cfg_next.subs  = cfg.data[4:0];
                REG_FRAC:   cfg_next.frac  = cfg.data[16:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // -------------------------------------------------------------------------
    // Future-current chain: shifts one place per step, kernel added on a spike.
    // -------------------------------------------------------------------------
    assign cctl = '{
        step:  actl.drive_en,
        spike: spiking_w,
        we:    load_w,
        idx:   item.tap_index,
        value: item.tap_value
    };

    gifs_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .head  (head_w)
    );

    gifs_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (actl),
        .drive   (item.drive_current),
        .noise   (item.noise_sample),
        .head    (head_w),
        .spiking (spiking_w),
        .voltage (volt_w),
        .spike   (spike_w),
        .hist    (hist_w)
    );

    // -------------------------------------------------------------------------
    // Result register
    // -------------------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (actl.gain_en)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (actl.gain_en)
        begin
            res_volt_reg  <= volt_w;
            res_spike_reg <= spike_w;
            res_hist_reg  <= hist_w;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.voltage         = res_volt_reg;
    assign result.spike           = res_spike_reg;
    assign result.history_current = res_hist_reg;

endmodule

`default_nettype wire
